@@ rtl/sbfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared constants, types and helpers of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int unsigned FRAME_BYTES   = 25;
  localparam int unsigned FLAG_POS      = 23;
  localparam int unsigned LAST_DATA_POS = 22;
  localparam int unsigned FIRST_DATA_POS = 1;
  localparam int unsigned CHANNELS      = 16;
  localparam int unsigned CH_BITS       = 11;
  localparam int unsigned CH_IDX_W      = 4;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned RAM_AW        = POS_W + 1;
  localparam int unsigned RAM_DEPTH     = 2 ** RAM_AW;
  localparam int unsigned ACC_W         = CH_BITS - 1 + BYTE_W;
  localparam int unsigned NBITS_W       = 5;
  localparam int unsigned LOST_BIT      = 2;
  localparam int unsigned FS_BIT        = 3;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] END_BYTE_A = 8'h00;
  localparam logic [BYTE_W-1:0] END_BYTE_B = 8'h04;
  localparam logic [BYTE_W-1:0] END_BYTE_C = 8'h07;

  typedef struct packed {
    logic valid;
    logic bank;
    logic frame_lost;
    logic failsafe;
  } start_t;

  function automatic logic end_ok(input logic [BYTE_W-1:0] b);
    return (b == END_BYTE_A) || (b == END_BYTE_B) || (b == END_BYTE_C);
  endfunction

endpackage

@@ rtl/sbfd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_if
// Valid/ready channels of the decoder: received bytes in, channels out.
// ----------------------------------------------------------------------------
interface sbfd_byte_if;
  import sbfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfd_chan_if;
  import sbfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_IDX_W-1:0] channel_index;
  logic [CH_BITS-1:0]  channel_value;
  logic                frame_lost;
  logic                failsafe;
  logic                last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output frame_lost, output failsafe, output last_channel,
                  input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input frame_lost, input failsafe, input last_channel,
                output ready);
endinterface

@@ rtl/sbfd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sbfd_rx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_rx
// Start-byte hunt and frame capture into the current bank of frame memory.
// ----------------------------------------------------------------------------
module sbfd_rx (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  sbfd_byte_if.sink               rx_i,
  input  logic                    unpack_busy_i,
  output logic                    we_o,
  output logic [sbfd_pkg::RAM_AW-1:0] waddr_o,
  output logic [sbfd_pkg::BYTE_W-1:0] wdata_o,
  output sbfd_pkg::start_t        start_o
);
  import sbfd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             bank_q, bank_d;
  logic             lost_q, lost_d;
  logic             fs_q, fs_d;
  logic             accept;
  logic             at_last;
  logic             good_end;

  assign at_last  = (pos_q == POS_W'(FRAME_BYTES - 1));
  assign rx_i.ready = !(at_last && unpack_busy_i);
  assign accept   = rx_i.valid && rx_i.ready;
  assign good_end = accept && at_last && end_ok(rx_i.rx_byte);

  assign waddr_o = {bank_q, pos_q};
  assign wdata_o = rx_i.rx_byte;

  always_comb begin
    we_o   = 1'b0;
    pos_d  = pos_q;
    bank_d = bank_q;
    lost_d = lost_q;
    fs_d   = fs_q;
    if (accept) begin
      if (pos_q == '0) begin
        if (rx_i.rx_byte == START_BYTE) begin
          we_o  = 1'b1;
          pos_d = POS_W'(1);
        end
      end else begin
        we_o = 1'b1;
        if (pos_q == POS_W'(FLAG_POS)) begin
          lost_d = rx_i.rx_byte[LOST_BIT];
          fs_d   = rx_i.rx_byte[FS_BIT];
        end
        if (at_last) begin
          pos_d = '0;
          if (good_end) begin
            bank_d = !bank_q;
          end
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    start_o.valid      = good_end;
    start_o.bank       = bank_q;
    start_o.frame_lost = lost_q;
    start_o.failsafe   = fs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bank_q <= 1'b0;
      lost_q <= 1'b0;
      fs_q   <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      bank_q <= bank_d;
      lost_q <= lost_d;
      fs_q   <= fs_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(FRAME_BYTES - 1))
    else $error("byte position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_o.valid |-> !unpack_busy_i)
    else $error("frame handed over while unpacker busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_o.valid |=> (pos_q == '0) && (bank_q != $past(bank_q)))
    else $error("bank not swapped after good frame");

endmodule

@@ rtl/sbfd_unpack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_unpack
// Reads a captured frame byte by byte and slices out sixteen 11-bit channels.
// ----------------------------------------------------------------------------
module sbfd_unpack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbfd_pkg::start_t            start_i,
  output logic                        busy_o,
  output logic                        re_o,
  output logic [sbfd_pkg::RAM_AW-1:0] raddr_o,
  input  logic [sbfd_pkg::BYTE_W-1:0] rdata_i,
  sbfd_chan_if.source                 ch_o
);
  import sbfd_pkg::*;

  logic                busy_q, busy_d;
  logic                bank_q, bank_d;
  logic                lost_q, lost_d;
  logic                fs_q, fs_d;
  logic [POS_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic                rd_pend_q, rd_pend_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [NBITS_W-1:0]  nbits_q, nbits_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;

  logic                out_valid_q, out_valid_d;
  logic [CH_IDX_W-1:0] out_idx_q, out_idx_d;
  logic [CH_BITS-1:0]  out_val_q, out_val_d;
  logic                out_lost_q, out_lost_d;
  logic                out_fs_q, out_fs_d;
  logic                out_last_q, out_last_d;

  logic                have_ch;
  logic                slot_free;
  logic                emit;

  assign have_ch   = (nbits_q >= NBITS_W'(CH_BITS));
  assign slot_free = !out_valid_q || ch_o.ready;
  assign emit      = busy_q && have_ch && slot_free;
  assign re_o      = busy_q && !rd_pend_q && !have_ch
                     && (rd_ptr_q <= POS_W'(LAST_DATA_POS));
  assign raddr_o   = {bank_q, rd_ptr_q};
  assign busy_o    = busy_q;

  always_comb begin
    busy_d      = busy_q;
    bank_d      = bank_q;
    lost_d      = lost_q;
    fs_d        = fs_q;
    rd_ptr_d    = rd_ptr_q;
    rd_pend_d   = re_o;
    acc_d       = acc_q;
    nbits_d     = nbits_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !ch_o.ready;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_lost_d  = out_lost_q;
    out_fs_d    = out_fs_q;
    out_last_d  = out_last_q;

    if (re_o) begin
      rd_ptr_d = rd_ptr_q + POS_W'(1);
    end
    if (rd_pend_q) begin
      acc_d   = acc_q | (ACC_W'(rdata_i) << nbits_q);
      nbits_d = nbits_q + NBITS_W'(BYTE_W);
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_idx_d   = ch_q;
      out_val_d   = acc_q[CH_BITS-1:0];
      out_lost_d  = lost_q;
      out_fs_d    = fs_q;
      out_last_d  = (ch_q == CH_IDX_W'(CHANNELS - 1));
      acc_d       = acc_q >> CH_BITS;
      nbits_d     = nbits_q - NBITS_W'(CH_BITS);
      ch_d        = ch_q + CH_IDX_W'(1);
      if (ch_q == CH_IDX_W'(CHANNELS - 1)) begin
        busy_d = 1'b0;
      end
    end
    if (start_i.valid) begin
      busy_d    = 1'b1;
      bank_d    = start_i.bank;
      lost_d    = start_i.frame_lost;
      fs_d      = start_i.failsafe;
      rd_ptr_d  = POS_W'(FIRST_DATA_POS);
      rd_pend_d = 1'b0;
      acc_d     = '0;
      nbits_d   = '0;
      ch_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      bank_q      <= 1'b0;
      rd_ptr_q    <= '0;
      nbits_q     <= '0;
      ch_q        <= '0;
    end else begin
      busy_q      <= busy_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      bank_q      <= bank_d;
      rd_ptr_q    <= rd_ptr_d;
      nbits_q     <= nbits_d;
      ch_q        <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lost_q     <= lost_d;
    fs_q       <= fs_d;
    acc_q      <= acc_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_lost_q <= out_lost_d;
    out_fs_q   <= out_fs_d;
    out_last_q <= out_last_d;
  end

  assign ch_o.valid         = out_valid_q;
  assign ch_o.channel_index = out_idx_q;
  assign ch_o.channel_value = out_val_q;
  assign ch_o.frame_lost    = out_lost_q;
  assign ch_o.failsafe      = out_fs_q;
  assign ch_o.last_channel  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !have_ch)
    else $error("read returned while a channel was already held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbits_q <= NBITS_W'(ACC_W))
    else $error("bit accumulator overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !busy_d && !start_i.valid) |-> (nbits_q == NBITS_W'(CH_BITS))
      && (rd_ptr_q == POS_W'(LAST_DATA_POS + 1)))
    else $error("frame finished with unread bytes");

endmodule

@@ rtl/sbus_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS frame decoder: received bytes in, sixteen channel transactions out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle and written into one bank of a two-bank frame
// memory. After a 25-byte frame that opens with 0x0F and closes with a valid
// end byte, the banks swap and the unpacker reads the captured bank through
// the single read port, one byte at a time, slicing a channel out each time
// 11 bits are held, until the frame has yielded its sixteen channels.
// Reception of the next frame runs meanwhile; only its last byte is held off
// while unpacking is in progress.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbfd_byte_if.sink   rx_i,
  sbfd_chan_if.source ch_o
);
  import sbfd_pkg::*;

  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [RAM_AW-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  logic              unpack_busy;
  start_t            start;

  sbfd_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .unpack_busy_i(unpack_busy),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .start_o      (start)
  );

  sbfd_ram #(
    .Width(BYTE_W),
    .Depth(RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sbfd_unpack u_unpack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (unpack_busy),
    .re_o   (re),
    .raddr_o(raddr),
    .rdata_i(rdata),
    .ch_o   (ch_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr[RAM_AW-1] != raddr[RAM_AW-1]))
    else $error("capture and unpack touch the same bank");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start.valid |=> unpack_busy)
    else $error("unpacker did not start on a good frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_o.valid && ch_o.last_channel) |-> (ch_o.channel_index == CH_IDX_W'(CHANNELS - 1)))
    else $error("last channel flag on wrong channel");

endmodule
